// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the job queue module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define XVC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("xvc assertion failed");

// Checks that a condition never holds outside reset.
`define XVC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `XVC_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== rtl/xvc_pkg.sv =====
package xvc_pkg;

  localparam int unsigned MaxVectorBytesDef = 1024;
  localparam int unsigned JobQueueDepth = 4;
  localparam int unsigned InfoLength = 20;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TDO  = 2'd1;
  localparam logic [1:0] FUNC_NEW  = 2'd2;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_JTAG  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_LENGTH  = 2'd1;
  localparam logic [1:0] REASON_UNKNOWN = 2'd2;

  localparam logic [7:0] CHAR_G = 8'h67;
  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_E = 8'h65;
  localparam logic [7:0] CHAR_H = 8'h68;

  typedef enum logic [3:0] {
    PH_CMD0,
    PH_CMD1,
    PH_GE,
    PH_SE,
    PH_SH,
    PH_DATA
  } phase_e;

  typedef enum logic [2:0] {
    JOB_CLOSE,
    JOB_INFO,
    JOB_ECHO,
    JOB_BITS,
    JOB_TDO
  } job_e;

  typedef struct packed {
    job_e        op;
    logic [31:0] data;
    logic [3:0]  nbits;
    logic [1:0]  reason;
    logic [7:0]  tms;
  } job_t;

  function automatic logic [7:0] info_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h78;
      5'd1:    b = 8'h76;
      5'd2:    b = 8'h63;
      5'd3:    b = 8'h53;
      5'd4:    b = 8'h65;
      5'd5:    b = 8'h72;
      5'd6:    b = 8'h76;
      5'd7:    b = 8'h65;
      5'd8:    b = 8'h72;
      5'd9:    b = 8'h5f;
      5'd10:   b = 8'h76;
      5'd11:   b = 8'h31;
      5'd12:   b = 8'h2e;
      5'd13:   b = 8'h30;
      5'd14:   b = 8'h3a;
      5'd15:   b = 8'h32;
      5'd16:   b = 8'h30;
      5'd17:   b = 8'h34;
      5'd18:   b = 8'h38;
      5'd19:   b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/xvc_ram.sv =====
module xvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/xvc_front.sv =====
module xvc_front #(
  parameter int unsigned MaxVectorBytes = xvc_pkg::MaxVectorBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        func_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              tdo_bit_i,
  output logic              job_push_o,
  output xvc_pkg::job_t     job_o,
  input  logic              job_full_i
);

  localparam int unsigned VbW = $clog2(MaxVectorBytes + 1);
  localparam int unsigned FbcW = VbW + 1;
  localparam int unsigned BitW = VbW + 3;
  localparam int unsigned AddrW = $clog2(MaxVectorBytes);

  xvc_pkg::phase_e phase_q, phase_d;
  logic [FbcW-1:0] fbc_q, fbc_d;
  logic [31:0]     len_q, len_d;
  logic [7:0]      first_q, first_d;
  logic [VbW-1:0]  vb_q, vb_d;
  logic [BitW-1:0] driven_q, driven_d;
  logic [BitW-1:0] rxcnt_q, rxcnt_d;
  logic [7:0]      acc_q, acc_d;
  logic [7:0]      echo_q [3];
  logic            stage_v_q, stage_v_d;
  xvc_pkg::job_t   stage_q, stage_d;

  logic            accept, is_byte, is_tdo, move;
  logic [FbcW-1:0] fbc_inc, k;
  logic [31:0]     sh_len, rem;
  logic [32:0]     vb_sum;
  logic [29:0]     vb_full;
  logic            sh_bad, data_store, data_drive;
  logic [3:0]      nb;
  logic            tdo_ok, tdo_emit, tdo_end;
  logic [BitW-1:0] rx_inc;
  logic [7:0]      acc_new;
  logic            ram_we, ram_re;
  logic [7:0]      ram_rdata;
  logic            job_v;
  xvc_pkg::job_t   job;

  assign move = stage_v_q && !job_full_i;
  assign full = stage_v_q && job_full_i;
  assign accept = push && !full;
  assign is_byte = accept && (func_i == xvc_pkg::FUNC_BYTE);
  assign is_tdo = accept && (func_i == xvc_pkg::FUNC_TDO);

  assign fbc_inc = fbc_q + FbcW'(1);
  assign sh_len = (fbc_q >= FbcW'(4))
      ? (len_q | ({24'd0, rx_byte_i} << {fbc_q[1:0], 3'b000})) : len_q;
  assign vb_sum = {1'b0, sh_len} + 33'd7;
  assign vb_full = vb_sum[32:3];
  assign sh_bad = sh_len[31] || (vb_full > 30'(MaxVectorBytes));

  assign data_store = fbc_q < {1'b0, vb_q};
  assign data_drive = !data_store && (fbc_q < {vb_q, 1'b0});
  assign k = fbc_q - {1'b0, vb_q};
  assign rem = len_q - (32'(k) << 3);
  assign nb = (rem > 32'd8) ? 4'd8 : rem[3:0];

  assign tdo_ok = (phase_q == xvc_pkg::PH_DATA) && (rxcnt_q < driven_q);
  assign rx_inc = rxcnt_q + BitW'(1);
  assign acc_new = acc_q | (8'(tdo_bit_i) << rxcnt_q[2:0]);
  assign tdo_end = 32'(rx_inc) == len_q;
  assign tdo_emit = (rx_inc[2:0] == 3'd0) || tdo_end;

  always_comb begin
    phase_d = phase_q;
    fbc_d = fbc_q;
    len_d = len_q;
    first_d = first_q;
    vb_d = vb_q;
    driven_d = driven_q;
    rxcnt_d = rxcnt_q;
    acc_d = acc_q;
    if (is_byte) begin
      case (phase_q)
        xvc_pkg::PH_CMD0: begin
          first_d = rx_byte_i;
          phase_d = xvc_pkg::PH_CMD1;
        end
        xvc_pkg::PH_CMD1: begin
          fbc_d = '0;
          if (first_q == xvc_pkg::CHAR_G && rx_byte_i == xvc_pkg::CHAR_E) begin
            phase_d = xvc_pkg::PH_GE;
          end else if (first_q == xvc_pkg::CHAR_S && rx_byte_i == xvc_pkg::CHAR_E) begin
            phase_d = xvc_pkg::PH_SE;
          end else if (first_q == xvc_pkg::CHAR_S && rx_byte_i == xvc_pkg::CHAR_H) begin
            phase_d = xvc_pkg::PH_SH;
          end else begin
            phase_d = xvc_pkg::PH_CMD0;
            first_d = '0;
          end
        end
        xvc_pkg::PH_GE: begin
          fbc_d = fbc_inc;
          if (fbc_inc >= FbcW'(6)) begin
            phase_d = xvc_pkg::PH_CMD0;
            fbc_d = '0;
            first_d = '0;
          end
        end
        xvc_pkg::PH_SE: begin
          fbc_d = fbc_inc;
          if (fbc_inc >= FbcW'(9)) begin
            phase_d = xvc_pkg::PH_CMD0;
            fbc_d = '0;
            first_d = '0;
          end
        end
        xvc_pkg::PH_SH: begin
          fbc_d = fbc_inc;
          len_d = sh_len;
          if (fbc_inc >= FbcW'(8)) begin
            if (sh_bad || vb_full == 30'd0) begin
              phase_d = xvc_pkg::PH_CMD0;
              fbc_d = '0;
              len_d = '0;
              first_d = '0;
            end else begin
              phase_d = xvc_pkg::PH_DATA;
              fbc_d = '0;
              vb_d = vb_full[VbW-1:0];
            end
          end
        end
        xvc_pkg::PH_DATA: begin
          if (data_store || data_drive) begin
            fbc_d = fbc_inc;
          end
          if (data_drive) begin
            driven_d = driven_q + BitW'(nb);
          end
        end
        default: begin
          phase_d = xvc_pkg::PH_CMD0;
          fbc_d = '0;
          len_d = '0;
          first_d = '0;
          vb_d = '0;
          driven_d = '0;
          rxcnt_d = '0;
          acc_d = '0;
        end
      endcase
    end else if (is_tdo && tdo_ok) begin
      rxcnt_d = rx_inc;
      acc_d = tdo_emit ? 8'd0 : acc_new;
      if (tdo_end) begin
        phase_d = xvc_pkg::PH_CMD0;
        fbc_d = '0;
        len_d = '0;
        first_d = '0;
        vb_d = '0;
        driven_d = '0;
        rxcnt_d = '0;
      end
    end else if (accept && func_i == xvc_pkg::FUNC_NEW) begin
      phase_d = xvc_pkg::PH_CMD0;
      fbc_d = '0;
      len_d = '0;
      first_d = '0;
      vb_d = '0;
      driven_d = '0;
      rxcnt_d = '0;
      acc_d = '0;
    end
  end

  always_comb begin
    job_v = 1'b0;
    job = '0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    if (is_byte) begin
      case (phase_q)
        xvc_pkg::PH_CMD1: begin
          if (!((first_q == xvc_pkg::CHAR_G && rx_byte_i == xvc_pkg::CHAR_E) ||
                (first_q == xvc_pkg::CHAR_S && rx_byte_i == xvc_pkg::CHAR_E) ||
                (first_q == xvc_pkg::CHAR_S && rx_byte_i == xvc_pkg::CHAR_H))) begin
            job_v = 1'b1;
            job.op = xvc_pkg::JOB_CLOSE;
            job.reason = xvc_pkg::REASON_UNKNOWN;
          end
        end
        xvc_pkg::PH_GE: begin
          if (fbc_inc >= FbcW'(6)) begin
            job_v = 1'b1;
            job.op = xvc_pkg::JOB_INFO;
          end
        end
        xvc_pkg::PH_SE: begin
          if (fbc_inc >= FbcW'(9)) begin
            job_v = 1'b1;
            job.op = xvc_pkg::JOB_ECHO;
            job.data = {rx_byte_i, echo_q[2], echo_q[1], echo_q[0]};
          end
        end
        xvc_pkg::PH_SH: begin
          if (fbc_inc >= FbcW'(8) && sh_bad) begin
            job_v = 1'b1;
            job.op = xvc_pkg::JOB_CLOSE;
            job.reason = xvc_pkg::REASON_LENGTH;
          end
        end
        xvc_pkg::PH_DATA: begin
          ram_we = data_store;
          if (data_drive) begin
            ram_re = 1'b1;
            job_v = 1'b1;
            job.op = xvc_pkg::JOB_BITS;
            job.data = {24'd0, rx_byte_i};
            job.nbits = nb;
          end
        end
        default: begin
          job_v = 1'b0;
        end
      endcase
    end else if (is_tdo && tdo_ok && tdo_emit) begin
      job_v = 1'b1;
      job.op = xvc_pkg::JOB_TDO;
      job.data = {24'd0, acc_new};
    end
  end

  xvc_ram #(
    .Width(8),
    .Depth(MaxVectorBytes)
  ) u_tms_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fbc_q[AddrW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(k[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    stage_v_d = stage_v_q;
    stage_d = stage_q;
    if (accept) begin
      stage_v_d = job_v;
      stage_d = job;
    end else if (move) begin
      stage_v_d = 1'b0;
    end
  end

  always_comb begin
    job_o = stage_q;
    if (stage_q.op == xvc_pkg::JOB_BITS) begin
      job_o.tms = ram_rdata;
    end
  end

  assign job_push_o = move;

  always_ff @(posedge clk_i) begin
    if (is_byte && phase_q == xvc_pkg::PH_SE && fbc_q >= FbcW'(5) &&
        fbc_q < FbcW'(8)) begin
      echo_q[fbc_q[1:0] - 2'd1] <= rx_byte_i;
    end
    stage_q <= stage_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xvc_pkg::PH_CMD0;
      fbc_q <= '0;
      len_q <= '0;
      first_q <= '0;
      vb_q <= '0;
      driven_q <= '0;
      rxcnt_q <= '0;
      acc_q <= '0;
      stage_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fbc_q <= fbc_d;
      len_q <= len_d;
      first_q <= first_d;
      vb_q <= vb_d;
      driven_q <= driven_d;
      rxcnt_q <= rxcnt_d;
      acc_q <= acc_d;
      stage_v_q <= stage_v_d;
    end
  end

endmodule

// ===== rtl/xvc_jobq.sv =====
`include "assert_macros.svh"

module xvc_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xvc_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output xvc_pkg::job_t rdata_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(xvc_pkg::JobQueueDepth);

  xvc_pkg::job_t   mem_q [xvc_pkg::JobQueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o = cnt_q == (PtrW + 1)'(xvc_pkg::JobQueueDepth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d = cnt_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  `XVC_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `XVC_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)
  `XVC_ASSERT(a_count_bound, clk_i, rst_ni, cnt_q <= (PtrW + 1)'(xvc_pkg::JobQueueDepth))

endmodule

// ===== rtl/xvc_back.sv =====
module xvc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  xvc_pkg::job_t job_i,
  input  logic          job_empty_i,
  output logic          job_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [1:0]    kind_o,
  output logic [7:0]    tx_byte_o,
  output logic          tms_bit_o,
  output logic          tdi_bit_o,
  output logic [1:0]    close_reason_o,
  output logic          last_o
);

  logic          cur_v_q, cur_v_d;
  xvc_pkg::job_t cur_q, cur_d;
  logic [4:0]    idx_q, idx_d;
  logic [4:0]    count;
  logic          done, load;

  always_comb begin
    case (cur_q.op)
      xvc_pkg::JOB_INFO: count = 5'(xvc_pkg::InfoLength);
      xvc_pkg::JOB_ECHO: count = 5'd4;
      xvc_pkg::JOB_BITS: count = {1'b0, cur_q.nbits};
      default:           count = 5'd1;
    endcase
  end

  assign last_o = idx_q == count - 5'd1;
  assign empty = !cur_v_q;
  assign done = cur_v_q && pop && last_o;
  assign load = !cur_v_q || done;
  assign job_pop_o = load && !job_empty_i;

  always_comb begin
    cur_v_d = cur_v_q;
    cur_d = cur_q;
    idx_d = idx_q;
    if (load) begin
      cur_v_d = !job_empty_i;
      cur_d = job_i;
      idx_d = '0;
    end else if (pop) begin
      idx_d = idx_q + 5'd1;
    end
  end

  always_comb begin
    kind_o = xvc_pkg::KIND_BYTE;
    tx_byte_o = '0;
    tms_bit_o = 1'b0;
    tdi_bit_o = 1'b0;
    close_reason_o = xvc_pkg::REASON_NONE;
    case (cur_q.op)
      xvc_pkg::JOB_CLOSE: begin
        kind_o = xvc_pkg::KIND_CLOSE;
        close_reason_o = cur_q.reason;
      end
      xvc_pkg::JOB_INFO: tx_byte_o = xvc_pkg::info_byte(idx_q);
      xvc_pkg::JOB_ECHO: tx_byte_o = cur_q.data[{idx_q[1:0], 3'b000} +: 8];
      xvc_pkg::JOB_BITS: begin
        kind_o = xvc_pkg::KIND_JTAG;
        tms_bit_o = cur_q.tms[idx_q[2:0]];
        tdi_bit_o = cur_q.data[idx_q[2:0]];
      end
      xvc_pkg::JOB_TDO: tx_byte_o = cur_q.data[7:0];
      default: tx_byte_o = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q <= '0;
    end else begin
      cur_v_q <= cur_v_d;
      idx_q <= idx_d;
    end
  end

endmodule

// ===== rtl/xvc_command_to_jtag_engine.sv =====
// Channel   Direction  Handshake     Fields
// input     in         push / full   func_i, rx_byte_i, tdo_bit_i
// result    out        empty / pop   kind_o, tx_byte_o, tms_bit_o, tdi_bit_o,
//                                    close_reason_o, last_o
// One input word is accepted per cycle while the front stage can drain into the job queue.
// Each word expands into zero to twenty back-part results, one per cycle while pop is high.
// A TDI byte gives up to eight results; queued jobs let input go on while the back part works.
// The TMS vector memory is read in the same cycle as its TDI byte is taken.
// Reset clears all control state at once; no clearing pass is needed.
module xvc_command_to_jtag_engine #(
  parameter int unsigned MaxVectorBytes = xvc_pkg::MaxVectorBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func_i,
  input  logic [7:0] rx_byte_i,
  input  logic       tdo_bit_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] tx_byte_o,
  output logic       tms_bit_o,
  output logic       tdi_bit_o,
  output logic [1:0] close_reason_o,
  output logic       last_o
);

  logic          q_push, q_full, q_pop, q_empty;
  xvc_pkg::job_t q_wdata, q_rdata;

  xvc_front #(
    .MaxVectorBytes(MaxVectorBytes)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .func_i    (func_i),
    .rx_byte_i (rx_byte_i),
    .tdo_bit_i (tdo_bit_i),
    .job_push_o(q_push),
    .job_o     (q_wdata),
    .job_full_i(q_full)
  );

  xvc_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  xvc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (q_rdata),
    .job_empty_i   (q_empty),
    .job_pop_o     (q_pop),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .tms_bit_o     (tms_bit_o),
    .tdi_bit_o     (tdi_bit_o),
    .close_reason_o(close_reason_o),
    .last_o        (last_o)
  );

endmodule

// ===== tb/sv/xvc_command_to_jtag_engine_test.sv =====
`timescale 1ns / 100ps

module xvc_command_to_jtag_engine_test;

  localparam int unsigned VecMax = xvc_pkg::MaxVectorBytesDef;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam logic [7:0] InfoText [xvc_pkg::InfoLength] = '{
    8'h78, 8'h76, 8'h63, 8'h53, 8'h65, 8'h72, 8'h76, 8'h65, 8'h72, 8'h5f,
    8'h76, 8'h31, 8'h2e, 8'h30, 8'h3a, 8'h32, 8'h30, 8'h34, 8'h38, 8'h0a
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       tms_bit;
    logic       tdi_bit;
    logic [1:0] close_reason;
    logic       last;
  } reply_t;

  class xvc_scoreboard;
    xvc_pkg::phase_e phase;
    logic [31:0] fcount;
    logic [31:0] nbits;
    logic [7:0]  tms_mem[VecMax];
    logic [7:0]  period[3];
    logic [7:0]  tdo_acc;
    logic [31:0] tdo_count;
    logic [7:0]  cmd_first;
    logic [31:0] driven;
    logic [31:0] nbytes;
    reply_t      pending[$];
    int          errors;
    int          checked;

    function void go_idle();
      phase = xvc_pkg::PH_CMD0;
      fcount = 0;
      nbits = 0;
      tdo_acc = 0;
      tdo_count = 0;
      cmd_first = 0;
      driven = 0;
      nbytes = 0;
    endfunction

    function void add(logic [1:0] k, logic [7:0] tx, logic tms, logic tdi,
                      logic [1:0] rs, logic lst);
      reply_t r;
      r.kind = k;
      r.tx_byte = tx;
      r.tms_bit = tms;
      r.tdi_bit = tdi;
      r.close_reason = rs;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void close_link(logic [1:0] rs);
      go_idle();
      add(xvc_pkg::KIND_CLOSE, 8'd0, 1'b0, 1'b0, rs, 1'b1);
    endfunction

    function void take_byte(logic [7:0] b);
      int n;
      logic [31:0] k;
      logic [7:0] tms;
      case (phase)
        xvc_pkg::PH_CMD0: begin
          cmd_first = b;
          phase = xvc_pkg::PH_CMD1;
        end
        xvc_pkg::PH_CMD1: begin
          fcount = 0;
          if (cmd_first == xvc_pkg::CHAR_G && b == xvc_pkg::CHAR_E) phase = xvc_pkg::PH_GE;
          else if (cmd_first == xvc_pkg::CHAR_S && b == xvc_pkg::CHAR_E) phase = xvc_pkg::PH_SE;
          else if (cmd_first == xvc_pkg::CHAR_S && b == xvc_pkg::CHAR_H) phase = xvc_pkg::PH_SH;
          else close_link(xvc_pkg::REASON_UNKNOWN);
        end
        xvc_pkg::PH_GE: begin
          fcount++;
          if (fcount >= 6) begin
            for (int i = 0; i < xvc_pkg::InfoLength; i++) begin
              add(xvc_pkg::KIND_BYTE, InfoText[i], 1'b0, 1'b0, xvc_pkg::REASON_NONE,
                  i == xvc_pkg::InfoLength - 1);
            end
            go_idle();
          end
        end
        xvc_pkg::PH_SE: begin
          if (fcount >= 5 && fcount < 8) period[fcount - 5] = b;
          fcount++;
          if (fcount >= 9) begin
            for (int i = 0; i < 3; i++) begin
              add(xvc_pkg::KIND_BYTE, period[i], 1'b0, 1'b0, xvc_pkg::REASON_NONE, 1'b0);
            end
            add(xvc_pkg::KIND_BYTE, b, 1'b0, 1'b0, xvc_pkg::REASON_NONE, 1'b1);
            go_idle();
          end
        end
        xvc_pkg::PH_SH: begin
          if (fcount >= 4) nbits |= 32'(b) << (8 * (fcount - 4));
          fcount++;
          if (fcount >= 8) begin
            nbytes = (nbits + 32'd7) >> 3;
            if (nbits[31] || nbytes > VecMax) close_link(xvc_pkg::REASON_LENGTH);
            else if (nbytes == 0) go_idle();
            else begin
              phase = xvc_pkg::PH_DATA;
              fcount = 0;
            end
          end
        end
        xvc_pkg::PH_DATA: begin
          if (fcount < nbytes) begin
            tms_mem[fcount] = b;
            fcount++;
          end else if (fcount < 2 * nbytes) begin
            k = fcount - nbytes;
            fcount++;
            n = (nbits - 8 * k > 8) ? 8 : int'(nbits - 8 * k);
            tms = tms_mem[k];
            for (int i = 0; i < n; i++) begin
              add(xvc_pkg::KIND_JTAG, 8'd0, tms[i], b[i], xvc_pkg::REASON_NONE, i + 1 == n);
            end
            driven += n;
          end
        end
        default: go_idle();
      endcase
    endfunction

    function void note_input(logic [1:0] func, logic [7:0] rx, logic tdo);
      if (func == xvc_pkg::FUNC_BYTE) begin
        take_byte(rx);
      end else if (func == xvc_pkg::FUNC_TDO) begin
        if (phase == xvc_pkg::PH_DATA && tdo_count < driven) begin
          tdo_acc[tdo_count[2:0]] = tdo;
          tdo_count++;
          if (tdo_count[2:0] == 0 || tdo_count == nbits) begin
            add(xvc_pkg::KIND_BYTE, tdo_acc, 1'b0, 1'b0, xvc_pkg::REASON_NONE, 1'b1);
            tdo_acc = 0;
            if (tdo_count == nbits) go_idle();
          end
        end
      end else if (func == xvc_pkg::FUNC_NEW) begin
        go_idle();
      end
    endfunction

    function void check_result(reply_t got);
      reply_t exp;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result word kind=%0d", got.kind);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d actual %0d", exp.kind, got.kind); errors++;
      end
      if (got.tx_byte !== exp.tx_byte) begin
        $error("tx_byte: expected %0h actual %0h", exp.tx_byte, got.tx_byte); errors++;
      end
      if (got.tms_bit !== exp.tms_bit) begin
        $error("tms_bit: expected %0b actual %0b", exp.tms_bit, got.tms_bit); errors++;
      end
      if (got.tdi_bit !== exp.tdi_bit) begin
        $error("tdi_bit: expected %0b actual %0b", exp.tdi_bit, got.tdi_bit); errors++;
      end
      if (got.close_reason !== exp.close_reason) begin
        $error("close_reason: expected %0d actual %0d", exp.close_reason,
               got.close_reason); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b actual %0b", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [1:0] func_i;
  logic [7:0] rx_byte_i;
  logic       tdo_bit_i;
  logic       empty;
  logic       pop;
  logic [1:0] kind_o;
  logic [7:0] tx_byte_o;
  logic       tms_bit_o;
  logic       tdi_bit_o;
  logic [1:0] close_reason_o;
  logic       last_o;

  xvc_scoreboard sb;
  bit calm;
  int cycles;
  int words_in;

  xvc_command_to_jtag_engine u_dut (
    .clk_i, .rst_ni, .push, .full, .func_i, .rx_byte_i, .tdo_bit_i,
    .empty, .pop, .kind_o, .tx_byte_o, .tms_bit_o, .tdi_bit_o,
    .close_reason_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_word(logic [1:0] func, logic [7:0] rx, logic tdo);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    push <= 1'b1;
    func_i <= func;
    rx_byte_i <= rx;
    tdo_bit_i <= tdo;
    do @(posedge clk_i); while (full);
    sb.note_input(func, rx, tdo);
    words_in++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(xvc_pkg::FUNC_BYTE, b, 1'($urandom));
  endtask

  task automatic send_tdo(logic b);
    send_word(xvc_pkg::FUNC_TDO, 8'($urandom), b);
  endtask

  task automatic send_len(logic [31:0] len);
    for (int i = 0; i < 4; i++) send_byte(len[8 * i +: 8]);
  endtask

  task automatic run_shift(logic [31:0] len, bit full_tdo, bit extra);
    int nb;
    send_byte(xvc_pkg::CHAR_S);
    send_byte(xvc_pkg::CHAR_H);
    send_byte(8'h69);
    send_byte(8'h66);
    send_byte(8'h74);
    send_byte(8'h3a);
    send_len(len);
    if (len[31] || ((len + 7) >> 3) > VecMax) return;
    nb = (len + 7) >> 3;
    for (int i = 0; i < nb; i++) send_byte(8'($urandom));
    for (int i = 0; i < nb; i++) send_byte(8'($urandom));
    if (extra) send_byte(8'($urandom));
    if (full_tdo) for (int i = 0; i < len; i++) send_tdo(1'($urandom));
    else if (len > 1) for (int i = 0; i < len / 2; i++) send_tdo(1'($urandom));
    if (extra) send_tdo(1'($urandom));
    if (!full_tdo) send_word(xvc_pkg::FUNC_NEW, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_settck();
    send_byte(xvc_pkg::CHAR_S);
    send_byte(xvc_pkg::CHAR_E);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom));
    for (int i = 0; i < 4; i++) send_byte(8'($urandom));
  endtask

  task automatic run_getinfo();
    send_byte(xvc_pkg::CHAR_G);
    send_byte(xvc_pkg::CHAR_E);
    for (int i = 0; i < 6; i++) send_byte(8'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (!empty && pop) begin
        sb.check_result({kind_o, tx_byte_o, tms_bit_o, tdi_bit_o, close_reason_o, last_o});
      end
      if (cycles > CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (burst > 0) begin
        burst--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int sel;
    sb = new();
    sb.go_idle();
    calm = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    func_i = xvc_pkg::FUNC_BYTE;
    rx_byte_i = 8'h00;
    tdo_bit_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_getinfo();
    run_settck();
    run_shift(32'd0, 1'b1, 1'b0);
    run_shift(32'h8000_0000, 1'b1, 1'b0);
    run_shift(32'hffff_ffff, 1'b1, 1'b0);
    run_shift(VecMax * 8 + 1, 1'b1, 1'b0);
    send_tdo(1'b1);
    send_byte(8'hff);
    send_byte(8'h00);
    send_word(FuncUnused, 8'hff, 1'b1);
    run_shift(32'd11, 1'b1, 1'b1);

    while (words_in < 190) begin
      sel = $urandom_range(0, 9);
      if (words_in > 150) calm = 1'b1;
      case (sel)
        0: run_getinfo();
        1, 2: run_settck();
        3, 4, 5: run_shift($urandom_range(1, 40), $urandom_range(0, 3) != 0,
                           1'($urandom_range(0, 1)));
        6: run_shift(($urandom_range(0, 1) << 31) | (VecMax * 8 + $urandom_range(1, 9000)),
                     1'b1, 1'b0);
        7: begin
          send_byte(8'($urandom));
          send_byte(8'($urandom));
        end
        8: send_word(xvc_pkg::FUNC_NEW, 8'($urandom), 1'($urandom));
        default: send_word(2'($urandom), 8'($urandom), 1'($urandom));
      endcase
    end
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Drove %0d input words and checked %0d result words.", words_in, sb.checked);
    $display("Covered getinfo, settck, shifts of many lengths, bad lengths and stray bytes.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/xvc_pkg.sv
rtl/xvc_ram.sv
rtl/xvc_front.sv
rtl/xvc_jobq.sv
rtl/xvc_back.sv
rtl/xvc_command_to_jtag_engine.sv
tb/sv/xvc_command_to_jtag_engine_test.sv
